// File: src/rtf_pkg.sv
// ----------------------------------------------------------------------------
// rtf_pkg
// Types and codes shared by the RTF token scanner modules.
// ----------------------------------------------------------------------------
package rtf_pkg;

    // token kinds
    localparam logic [2:0] KIND_CHAR   = 3'd0;
    localparam logic [2:0] KIND_OPEN   = 3'd1;
    localparam logic [2:0] KIND_CLOSE  = 3'd2;
    localparam logic [2:0] KIND_WORD   = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;
    localparam logic [2:0] KIND_END    = 3'd5;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BS_END    = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd3;
    localparam logic [2:0] ERR_BAD_DEST  = 3'd4;
    localparam logic [2:0] ERR_DEST_EXP  = 3'd5;

    // special bytes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DROP   = 8'hFF;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ESC,
        PH_STAR,
        PH_STARESC,
        PH_HEX1,
        PH_HEX2,
        PH_WORD,
        PH_ARG
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_mark;
    } t_in;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         char_value;
        logic [2:0]         error_code;
        logic               is_destination;
        logic [63:0]        word_head;
        logic [4:0]         word_length;
        logic [15:0]        word_sum;
        logic               has_arg;
        logic signed [31:0] arg_value;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [1:0] count;
        t_out       tok0;
        t_out       tok1;
    } t_tok_pair;

endpackage

// File: src/rtf_token_scanner.sv
// ----------------------------------------------------------------------------
// rtf_token_scanner
// RTF byte stream tokenizer: characters, groups, escapes, control words.
// ----------------------------------------------------------------------------
//  channel   valid / ready              payload
//  input     i_in_valid / o_in_ready    i_in_data  (data_byte, end_mark)
//  output    o_out_valid / i_out_ready  o_out_data (token)
//
//  one byte per cycle while the queue has room; its tokens (zero, one or two)
//  are in the queue the next cycle, and each token leaves on its own cycle
//  synchronous active-low reset returns the scanner to idle, queue empty
//  input is taken while the four-entry token queue has room for two tokens
//  a byte that gives two tokens holds two queue slots
// ----------------------------------------------------------------------------
module rtf_token_scanner #(
    parameter int MAX_WORD_LEN = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rtf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rtf_pkg::t_out o_out_data
);

    logic               accept;
    rtf_pkg::t_tok_pair toks;

    assign accept = i_in_valid && o_in_ready;

    rtf_tok_scan #(
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (accept),
        .i_data (i_in_data),
        .o_toks (toks)
    );

    rtf_tok_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_toks (toks),
        .o_room (o_in_ready),
        .o_valid(o_out_valid),
        .o_data (o_out_data),
        .i_ready(i_out_ready)
    );

endmodule

// File: src/rtf_tok_scan.sv
// ----------------------------------------------------------------------------
// rtf_tok_scan
// Scanner state and token decode: one byte per enable, up to two tokens.
// ----------------------------------------------------------------------------
module rtf_tok_scan #(
    parameter int MAX_WORD_LEN = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  rtf_pkg::t_in     i_data,
    output rtf_pkg::t_tok_pair o_toks
);

    rtf_pkg::t_phase r_phase, n_phase;
    logic [63:0] r_letters, n_letters;
    logic [4:0]  r_count, n_count;
    logic [15:0] r_sum, n_sum;
    logic        r_dest, n_dest;
    logic [31:0] r_accum, n_accum;
    logic        r_neg, n_neg;
    logic [7:0]  r_hex_high, n_hex_high;

    logic [7:0]  b;
    logic        at_end;
    logic [35:0] acc_mul;
    logic [31:0] acc_next;

    assign b      = i_data.data_byte;
    assign at_end = i_data.end_mark;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd16;
        if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
        else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
        return t[4:0];
    endfunction

    function automatic rtf_pkg::t_out mk_tok(input logic [2:0] kind, input logic [7:0] chv,
                                             input logic [2:0] err);
        rtf_pkg::t_out t;
        t            = '0;
        t.kind       = kind;
        t.char_value = chv;
        t.error_code = err;
        return t;
    endfunction

    // argument digit: accum * 10 + digit, saturated at 2^31
    assign acc_mul  = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + {32'd0, b[3:0]};
    assign acc_next = (acc_mul > 36'h080000000) ? 32'h80000000 : acc_mul[31:0];

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_letters  = r_letters;
        n_count    = r_count;
        n_sum      = r_sum;
        n_dest     = r_dest;
        n_accum    = r_accum;
        n_neg      = r_neg;
        n_hex_high = r_hex_high;
        if (at_end) begin
            n_phase    = rtf_pkg::PH_IDLE;
            n_letters  = '0;
            n_count    = '0;
            n_sum      = '0;
            n_dest     = 1'b0;
            n_accum    = '0;
            n_neg      = 1'b0;
            n_hex_high = '0;
        end else begin
            unique case (r_phase)
                rtf_pkg::PH_ESC: begin
                    n_phase = rtf_pkg::PH_IDLE;
                    if (b == rtf_pkg::CH_STAR) begin
                        n_phase = rtf_pkg::PH_STAR;
                    end else if (b == rtf_pkg::CH_QUOTE) begin
                        n_phase = rtf_pkg::PH_HEX1;
                    end else if (is_alpha(b)) begin
                        n_phase   = rtf_pkg::PH_WORD;
                        n_letters = {56'd0, b};
                        n_count   = 5'd1;
                        n_sum     = {8'd0, b};
                        n_dest    = 1'b0;
                        n_accum   = '0;
                        n_neg     = 1'b0;
                    end
                end
                rtf_pkg::PH_STAR: begin
                    n_phase = (b == rtf_pkg::CH_BSLASH) ? rtf_pkg::PH_STARESC
                                                        : rtf_pkg::PH_IDLE;
                end
                rtf_pkg::PH_STARESC: begin
                    n_phase = rtf_pkg::PH_IDLE;
                    if (is_alpha(b)) begin
                        n_phase   = rtf_pkg::PH_WORD;
                        n_letters = {56'd0, b};
                        n_count   = 5'd1;
                        n_sum     = {8'd0, b};
                        n_dest    = 1'b1;
                        n_accum   = '0;
                        n_neg     = 1'b0;
                    end
                end
                rtf_pkg::PH_HEX1: begin
                    n_hex_high = b;
                    n_phase    = rtf_pkg::PH_HEX2;
                end
                rtf_pkg::PH_HEX2: begin
                    n_hex_high = '0;
                    n_phase    = rtf_pkg::PH_IDLE;
                end
                rtf_pkg::PH_WORD, rtf_pkg::PH_ARG: begin
                    if (r_phase == rtf_pkg::PH_WORD && is_alpha(b)) begin
                        if (r_count < 5'(MAX_WORD_LEN)) begin
                            if (r_count < 5'd8) begin
                                n_letters[8*r_count[2:0] +: 8] = r_letters[8*r_count[2:0] +: 8] | b;
                            end
                            n_count = r_count + 5'd1;
                            n_sum   = r_sum + {8'd0, b};
                        end
                    end else if (r_phase == rtf_pkg::PH_WORD && b == rtf_pkg::CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = rtf_pkg::PH_ARG;
                    end else if (is_digit(b)) begin
                        n_accum = acc_next;
                        n_phase = rtf_pkg::PH_ARG;
                    end else begin
                        n_letters = '0;
                        n_count   = '0;
                        n_sum     = '0;
                        n_dest    = 1'b0;
                        n_accum   = '0;
                        n_neg     = 1'b0;
                        n_phase   = (!is_space(b) && b == rtf_pkg::CH_BSLASH)
                                  ? rtf_pkg::PH_ESC : rtf_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = (b == rtf_pkg::CH_BSLASH) ? rtf_pkg::PH_ESC : rtf_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // token outputs
    always_comb begin
        rtf_pkg::t_out word_t, a_t, b_t;
        logic          a_v, b_v, plain_v, with_arg;
        rtf_pkg::t_out plain_t;
        logic [4:0]    hv, lv;

        with_arg = (r_phase == rtf_pkg::PH_ARG);
        word_t                = '0;
        word_t.kind           = rtf_pkg::KIND_WORD;
        word_t.is_destination = r_dest;
        word_t.word_head      = r_letters;
        word_t.word_length    = r_count;
        word_t.word_sum       = r_sum;
        if (with_arg) begin
            word_t.has_arg   = 1'b1;
            word_t.arg_value = r_neg ? (32'd0 - r_accum)
                             : (r_accum[31] ? 32'h7FFFFFFF : r_accum);
        end

        plain_v = 1'b1;
        plain_t = mk_tok(rtf_pkg::KIND_CHAR, b, rtf_pkg::ERR_NONE);
        if (b == rtf_pkg::CH_BSLASH || b == rtf_pkg::CH_DROP) plain_v = 1'b0;
        else if (b == rtf_pkg::CH_LBRACE)
            plain_t = mk_tok(rtf_pkg::KIND_OPEN, 8'd0, rtf_pkg::ERR_NONE);
        else if (b == rtf_pkg::CH_RBRACE)
            plain_t = mk_tok(rtf_pkg::KIND_CLOSE, 8'd0, rtf_pkg::ERR_NONE);

        hv = hex_val(r_hex_high);
        lv = hex_val(b);

        a_v = 1'b0;
        a_t = '0;
        b_v = 1'b0;
        b_t = '0;

        if (at_end) begin
            b_v = 1'b1;
            b_t = mk_tok(rtf_pkg::KIND_END, 8'd0, rtf_pkg::ERR_NONE);
            unique case (r_phase)
                rtf_pkg::PH_ESC, rtf_pkg::PH_STAR, rtf_pkg::PH_STARESC: begin
                    a_v = 1'b1;
                    a_t = mk_tok(rtf_pkg::KIND_ERROR, 8'd0, rtf_pkg::ERR_BS_END);
                end
                rtf_pkg::PH_HEX1, rtf_pkg::PH_HEX2: begin
                    a_v = 1'b1;
                    a_t = mk_tok(rtf_pkg::KIND_ERROR, 8'd0, rtf_pkg::ERR_BAD_HEX);
                end
                rtf_pkg::PH_WORD, rtf_pkg::PH_ARG: begin
                    a_v = 1'b1;
                    a_t = word_t;
                end
                default: begin
                    a_v = 1'b0;
                end
            endcase
        end else begin
            unique case (r_phase)
                rtf_pkg::PH_ESC: begin
                    if (b == rtf_pkg::CH_BSLASH || b == rtf_pkg::CH_LBRACE
                        || b == rtf_pkg::CH_RBRACE || b == rtf_pkg::CH_UNDER) begin
                        a_v = 1'b1;
                        a_t = mk_tok(rtf_pkg::KIND_CHAR, b, rtf_pkg::ERR_NONE);
                    end else if (b != rtf_pkg::CH_STAR && b != rtf_pkg::CH_QUOTE
                                 && !is_alpha(b)) begin
                        a_v = 1'b1;
                        a_t = mk_tok(rtf_pkg::KIND_ERROR, 8'd0, rtf_pkg::ERR_BAD_ESC);
                    end
                end
                rtf_pkg::PH_STAR: begin
                    if (b != rtf_pkg::CH_BSLASH) begin
                        a_v = 1'b1;
                        a_t = mk_tok(rtf_pkg::KIND_ERROR, 8'd0, rtf_pkg::ERR_DEST_EXP);
                    end
                end
                rtf_pkg::PH_STARESC: begin
                    if (!is_alpha(b)) begin
                        a_v = 1'b1;
                        a_t = mk_tok(rtf_pkg::KIND_ERROR, 8'd0, rtf_pkg::ERR_BAD_DEST);
                    end
                end
                rtf_pkg::PH_HEX1: begin
                    a_v = 1'b0;
                end
                rtf_pkg::PH_HEX2: begin
                    a_v = 1'b1;
                    if (!hv[4] && !lv[4])
                        a_t = mk_tok(rtf_pkg::KIND_CHAR, {hv[3:0], lv[3:0]}, rtf_pkg::ERR_NONE);
                    else
                        a_t = mk_tok(rtf_pkg::KIND_ERROR, 8'd0, rtf_pkg::ERR_BAD_HEX);
                end
                rtf_pkg::PH_WORD, rtf_pkg::PH_ARG: begin
                    if (!(is_digit(b) || (r_phase == rtf_pkg::PH_WORD
                          && (is_alpha(b) || b == rtf_pkg::CH_MINUS)))) begin
                        a_v = 1'b1;
                        a_t = word_t;
                        if (!is_space(b)) begin
                            b_v = plain_v;
                            b_t = plain_t;
                        end
                    end
                end
                default: begin
                    b_v = plain_v;
                    b_t = plain_t;
                end
            endcase
        end

        o_toks = '0;
        if (a_v && b_v) begin
            o_toks.count     = 2'd2;
            o_toks.tok0      = a_t;
            o_toks.tok1      = b_t;
            o_toks.tok1.last = 1'b1;
        end else if (a_v) begin
            o_toks.count     = 2'd1;
            o_toks.tok0      = a_t;
            o_toks.tok0.last = 1'b1;
        end else if (b_v) begin
            o_toks.count     = 2'd1;
            o_toks.tok0      = b_t;
            o_toks.tok0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= rtf_pkg::PH_IDLE;
            r_letters  <= '0;
            r_count    <= '0;
            r_sum      <= '0;
            r_dest     <= 1'b0;
            r_accum    <= '0;
            r_neg      <= 1'b0;
            r_hex_high <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_letters  <= n_letters;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_dest     <= n_dest;
            r_accum    <= n_accum;
            r_neg      <= n_neg;
            r_hex_high <= n_hex_high;
        end
    end

endmodule

// File: src/rtf_tok_queue.sv
// ----------------------------------------------------------------------------
// rtf_tok_queue
// Four-entry token queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module rtf_tok_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rtf_pkg::t_tok_pair i_toks,
    output logic               o_room,
    output logic               o_valid,
    output rtf_pkg::t_out      o_data,
    input  logic               i_ready
);

    rtf_pkg::t_out r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic [1:0] push_n;
    logic       pop;

    assign push_n  = i_push ? i_toks.count : 2'd0;
    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= 3'd2);
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + push_n;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, push_n} - {2'd0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_toks.tok0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_toks.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: sim/rtf_token_checker.sv
// ----------------------------------------------------------------------------
// rtf_token_checker
// Watches the input and output channels of the RTF token scanner, predicts
// the tokens of every accepted byte or end mark and compares them in order,
// field by field, with the tokens that leave the block.
// ----------------------------------------------------------------------------
module rtf_token_checker import rtf_pkg::*; #(
    parameter int MAX_WORD_LEN = 31
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    t_phase      phase;
    logic [63:0] letters;
    logic [4:0]  n_letters;
    logic [15:0] letter_sum;
    logic        dest;
    logic [31:0] magnitude;
    logic        negative;
    logic [7:0]  hex_hi;

    t_out step_tokens[$];
    t_out expected_tokens[$];

    function automatic logic is_letter(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_blank(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [4:0] hex_nibble(logic [7:0] b);
        if (is_digit(b)) return 5'(b - "0");
        if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
        if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
        return 5'd16;
    endfunction

    task automatic clear_word();
        letters = '0;
        n_letters = '0;
        letter_sum = '0;
        dest = 1'b0;
        magnitude = '0;
        negative = 1'b0;
    endtask

    task automatic push_token(logic [2:0] kind, logic [7:0] chv, logic [2:0] err);
        t_out t;
        t = '0;
        t.kind = kind;
        t.char_value = chv;
        t.error_code = err;
        step_tokens.push_back(t);
    endtask

    task automatic push_word(logic with_arg);
        t_out t;
        t = '0;
        t.kind = KIND_WORD;
        t.is_destination = dest;
        t.word_head = letters;
        t.word_length = n_letters;
        t.word_sum = letter_sum;
        if (with_arg) begin
            t.has_arg = 1'b1;
            if (negative)
                t.arg_value = -magnitude;
            else
                t.arg_value = (magnitude > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : magnitude;
        end
        step_tokens.push_back(t);
        clear_word();
        phase = PH_IDLE;
    endtask

    task automatic start_word(logic [7:0] b, logic is_dest);
        clear_word();
        dest = is_dest;
        letters = 64'(b);
        n_letters = 5'd1;
        letter_sum = 16'(b);
        phase = PH_WORD;
    endtask

    task automatic add_digit(logic [7:0] b);
        logic [63:0] m;
        m = 64'(magnitude) * 64'd10 + 64'(b - "0");
        magnitude = (m > 64'h8000_0000) ? 32'h8000_0000 : m[31:0];
    endtask

    task automatic plain_byte(logic [7:0] b);
        phase = PH_IDLE;
        if (b == CH_BSLASH)
            phase = PH_ESC;
        else if (b == CH_LBRACE)
            push_token(KIND_OPEN, 8'd0, ERR_NONE);
        else if (b == CH_RBRACE)
            push_token(KIND_CLOSE, 8'd0, ERR_NONE);
        else if (b != CH_DROP)
            push_token(KIND_CHAR, b, ERR_NONE);
    endtask

    task automatic scan_request(t_in req);
        logic [7:0] b;
        logic [4:0] hi;
        logic [4:0] lo;
        t_out t;
        b = req.data_byte;
        step_tokens.delete();
        if (req.end_mark) begin
            case (phase)
                PH_ESC, PH_STAR, PH_STARESC: push_token(KIND_ERROR, 8'd0, ERR_BS_END);
                PH_HEX1, PH_HEX2: push_token(KIND_ERROR, 8'd0, ERR_BAD_HEX);
                PH_WORD: push_word(1'b0);
                PH_ARG: push_word(1'b1);
                default: ;
            endcase
            push_token(KIND_END, 8'd0, ERR_NONE);
            phase = PH_IDLE;
            hex_hi = '0;
            clear_word();
        end else begin
            case (phase)
                PH_ESC: begin
                    phase = PH_IDLE;
                    if (b == CH_STAR)
                        phase = PH_STAR;
                    else if (b == CH_BSLASH || b == CH_LBRACE || b == CH_RBRACE
                             || b == CH_UNDER)
                        push_token(KIND_CHAR, b, ERR_NONE);
                    else if (b == CH_QUOTE)
                        phase = PH_HEX1;
                    else if (is_letter(b))
                        start_word(b, 1'b0);
                    else
                        push_token(KIND_ERROR, 8'd0, ERR_BAD_ESC);
                end
                PH_STAR: begin
                    if (b == CH_BSLASH) begin
                        phase = PH_STARESC;
                    end else begin
                        phase = PH_IDLE;
                        push_token(KIND_ERROR, 8'd0, ERR_DEST_EXP);
                    end
                end
                PH_STARESC: begin
                    if (is_letter(b)) begin
                        start_word(b, 1'b1);
                    end else begin
                        phase = PH_IDLE;
                        push_token(KIND_ERROR, 8'd0, ERR_BAD_DEST);
                    end
                end
                PH_HEX1: begin
                    hex_hi = b;
                    phase = PH_HEX2;
                end
                PH_HEX2: begin
                    hi = hex_nibble(hex_hi);
                    lo = hex_nibble(b);
                    phase = PH_IDLE;
                    if (hi < 5'd16 && lo < 5'd16)
                        push_token(KIND_CHAR, {hi[3:0], lo[3:0]}, ERR_NONE);
                    else
                        push_token(KIND_ERROR, 8'd0, ERR_BAD_HEX);
                    hex_hi = '0;
                end
                PH_WORD: begin
                    if (is_letter(b)) begin
                        if (n_letters < MAX_WORD_LEN) begin
                            if (n_letters < 8) letters[8 * n_letters +: 8] = b;
                            n_letters = n_letters + 5'd1;
                            letter_sum = letter_sum + 16'(b);
                        end
                    end else if (b == CH_MINUS) begin
                        negative = 1'b1;
                        phase = PH_ARG;
                    end else if (is_digit(b)) begin
                        add_digit(b);
                        phase = PH_ARG;
                    end else begin
                        push_word(1'b0);
                        if (!is_blank(b)) plain_byte(b);
                    end
                end
                PH_ARG: begin
                    if (is_digit(b)) begin
                        add_digit(b);
                    end else begin
                        push_word(1'b1);
                        if (!is_blank(b)) plain_byte(b);
                    end
                end
                default: plain_byte(b);
            endcase
        end
        if (step_tokens.size() > 0) begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_token(t_out got);
        t_out want;
        if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none actual %h", $time, got);
            o_fail_count++;
        end else begin
            want = expected_tokens.pop_front();
            check_field("kind", 64'(want.kind), 64'(got.kind));
            check_field("char_value", 64'(want.char_value), 64'(got.char_value));
            check_field("error_code", 64'(want.error_code), 64'(got.error_code));
            check_field("is_destination", 64'(want.is_destination),
                        64'(got.is_destination));
            check_field("word_head", want.word_head, got.word_head);
            check_field("word_length", 64'(want.word_length), 64'(got.word_length));
            check_field("word_sum", 64'(want.word_sum), 64'(got.word_sum));
            check_field("has_arg", 64'(want.has_arg), 64'(got.has_arg));
            check_field("arg_value", 64'(unsigned'(want.arg_value)),
                        64'(unsigned'(got.arg_value)));
            check_field("last", 64'(want.last), 64'(got.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = PH_IDLE;
            hex_hi = '0;
            clear_word();
            expected_tokens.delete();
        end else begin
            if (i_in_valid && i_in_ready) scan_request(i_in_data);
            if (i_out_valid && i_out_ready) check_token(i_out_data);
        end
        o_pending = expected_tokens.size();
    end

endmodule

// File: sim/rtf_token_scanner_test.sv
// ----------------------------------------------------------------------------
// rtf_token_scanner_test
// Drives RTF bytes and end marks into the token scanner: a short directed
// stream, then random well-formed escapes, control words and hex escapes mixed
// with broken ones, under changing idle and stall rates and a long receiver
// hold-off. The checker beside the block predicts and compares the tokens.
// ----------------------------------------------------------------------------
module rtf_token_scanner_test;
    import rtf_pkg::*;

    localparam int PERIOD      = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 150;
    localparam int HOLD_AT     = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int requests_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    logic hold_done = 1'b0;

    logic [8:0] opening [0:23] = '{
        9'h000, 9'h0FF, {1'b0, CH_LBRACE}, {1'b0, CH_BSLASH}, {1'b0, CH_BSLASH},
        {1'b0, CH_BSLASH}, {1'b0, CH_QUOTE}, {1'b0, 8'h66}, {1'b0, 8'h41},
        {1'b0, CH_BSLASH}, {1'b0, CH_STAR}, {1'b0, CH_BSLASH}, {1'b0, 8'h78},
        {1'b0, CH_MINUS}, {1'b0, 8'h37}, {1'b0, CH_RBRACE}, {1'b0, CH_BSLASH},
        9'h0FF, {1'b0, CH_BSLASH}, {1'b0, CH_QUOTE}, {1'b0, 8'h7A}, 9'h1AA,
        {1'b0, CH_BSLASH}, 9'h155
    };

    always #(PERIOD / 2) clk = ~clk;

    rtf_token_scanner DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    rtf_token_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off once enough requests went in
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && requests_sent >= HOLD_AT) begin
            out_ready <= 1'b0;
            hold_cycles <= HOLD_LEN - 1;
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(logic [7:0] b, logic eom);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: b, end_mark: eom};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic send_letters(int n);
        int k;
        repeat (n) begin
            k = $urandom_range(51);
            send_request((k < 26) ? 8'(8'h41 + k) : 8'(8'h61 + k - 26), 1'b0);
        end
    endtask

    task automatic send_digits(int n);
        repeat (n) send_request(8'(8'h30 + $urandom_range(9)), 1'b0);
    endtask

    task automatic send_hex_digit();
        int k;
        k = $urandom_range(21);
        if ($urandom_range(99) < 12)
            send_request(8'($urandom_range(255)), 1'b0);
        else if (k < 10)
            send_request(8'(8'h30 + k), 1'b0);
        else if (k < 16)
            send_request(8'(8'h41 + k - 10), 1'b0);
        else
            send_request(8'(8'h61 + k - 16), 1'b0);
    endtask

    task automatic send_control_word();
        int r;
        send_request(CH_BSLASH, 1'b0);
        if ($urandom_range(3) == 0) begin
            send_request(CH_STAR, 1'b0);
            send_request(CH_BSLASH, 1'b0);
        end
        if ($urandom_range(9) == 0)
            send_letters($urandom_range(29, 40));
        else
            send_letters($urandom_range(1, 8));
        r = $urandom_range(9);
        if (r == 4) begin
            send_request(CH_MINUS, 1'b0);
        end else if (r >= 5) begin
            if ($urandom_range(1)) send_request(CH_MINUS, 1'b0);
            if (r >= 8)
                send_digits($urandom_range(9, 12));
            else
                send_digits($urandom_range(1, 4));
        end
        r = $urandom_range(9);
        case (r)
            0, 1, 2: send_request(8'h20, 1'b0);
            3: send_request(8'($urandom_range(9, 13)), 1'b0);
            4: send_request(CH_LBRACE, 1'b0);
            5: send_request(CH_RBRACE, 1'b0);
            6: send_request(CH_BSLASH, 1'b0);
            7: send_request(8'($urandom_range(255)), 1'b0);
            default: ;
        endcase
    endtask

    task automatic send_fragment();
        int sel;
        int r;
        sel = $urandom_range(99);
        if (sel < 18) begin
            send_request(8'($urandom_range(255)), 1'b0);
        end else if (sel < 24) begin
            send_request($urandom_range(1) ? CH_LBRACE : CH_RBRACE, 1'b0);
        end else if (sel < 30) begin
            send_request(CH_BSLASH, 1'b0);
            r = $urandom_range(3);
            send_request((r == 0) ? CH_BSLASH : (r == 1) ? CH_LBRACE :
                         (r == 2) ? CH_RBRACE : CH_UNDER, 1'b0);
        end else if (sel < 40) begin
            send_request(CH_BSLASH, 1'b0);
            send_request(CH_QUOTE, 1'b0);
            send_hex_digit();
            send_hex_digit();
        end else if (sel < 80) begin
            send_control_word();
        end else if (sel < 92) begin
            send_request(CH_BSLASH, 1'b0);
            r = $urandom_range(2);
            if (r >= 1) send_request(CH_STAR, 1'b0);
            if (r == 2) send_request(CH_BSLASH, 1'b0);
            send_request(8'($urandom_range(255)), 1'b0);
        end else if (sel < 96) begin
            send_request(8'($urandom_range(255)), 1'b1);
        end else begin
            send_request(($urandom_range(1)) ? CH_DROP : 8'($urandom_range(9, 13)), 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening[i]) send_request(opening[i][7:0], opening[i][8]);
        in_valid <= 1'b0;
        wait_drained();
        @(negedge clk);

        // no idling, with a long receiver hold-off while requests keep coming
        while (requests_sent < 140) send_fragment();
        while (requests_sent < 170) send_fragment();

        send_idle_pct = 62;
        recv_stall_pct = 0;
        while (requests_sent < 300) send_fragment();

        in_valid <= 1'b0;
        wait_drained();
        @(negedge clk);

        send_idle_pct = 0;
        recv_stall_pct = 62;
        while (requests_sent < 430) send_fragment();

        send_idle_pct = 34;
        recv_stall_pct = 34;
        while (requests_sent < 550) send_fragment();
        send_request(8'($urandom_range(255)), 1'b1);

        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
src/rtf_pkg.sv
src/rtf_tok_scan.sv
src/rtf_tok_queue.sv
src/rtf_token_scanner.sv
sim/rtf_token_checker.sv
sim/rtf_token_scanner_test.sv
